### rtl/core/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg: shared types and constants of the delimiter splitter
// Holds the result record, the configuration register indexes and the
// fixed field widths of the stream channels.
// ----------------------------------------------------------------------------
package dss_pkg;

	// Fixed field widths
	localparam int unsigned FIELD_W    = 16;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned DLEN_W     = 4;
	localparam int unsigned DBYTES_W   = 64;
	localparam int unsigned LIMIT_W    = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned OUT_DATA_W = 3 * FIELD_W;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELIM_LEN   = 2'd0,
		REG_DELIM_BYTES = 2'd1,
		REG_PIECE_LIMIT = 2'd2
	} cfg_reg_t;

	// One result item
	typedef struct packed {
		logic [FIELD_W-1:0] piece_start;
		logic [FIELD_W-1:0] piece_length;
		logic [FIELD_W-1:0] piece_index;
		logic               last_piece;
		logic               too_long;
	} result_t;

endpackage

### rtl/core/delimiter_split_with_limit_core.sv
// ----------------------------------------------------------------------------
// delimiter_split_with_limit_core: streaming string splitter with piece limit
// Cuts a byte stream on a configured delimiter of up to eight bytes and
// reports start, length and index of every piece, remainder last.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item per byte. s_tdata carries the byte, s_tuser
//   marks that the byte is present (clear for an empty string end) and
//   s_tlast closes the string. Output channel m_*: one item per piece,
//   m_tlast marks the closing remainder, m_tuser flags a string whose
//   offsets saturated.
//   Each accepted item is matched against the delimiter window in the same
//   cycle; its zero, one or two result items enter a four-entry output
//   queue, whose head drives m_*.
//   Throughput is one byte per cycle; s_tready stays high while the queue
//   has room for the two results that a single item may cause, so the
//   rate is bounded only by the output side draining one piece per cycle.
//   When the receiver stalls the queue fills and s_tready drops; nothing
//   is lost or repeated.
//   Reset empties the queue, clears the string state and loads a one-byte comma
//   delimiter with no piece limit. Write configuration through cfg_wr_en / cfg_index /
//   cfg_wdata while no string is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module delimiter_split_with_limit_core
	import dss_pkg::*;
#(
	parameter int unsigned MAX_DELIMITER_BYTES = 8,
	parameter int unsigned OFFSET_BITS         = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DBYTES_W-1:0]   cfg_wdata,
	// Input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
	input  logic                  s_tuser,   // [0] byte_valid
	input  logic                  s_tlast,   // last_byte
	// Output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] piece_start, [31:16] piece_length,
	                                         // [47:32] piece_index
	output logic                  m_tuser,   // [0] too_long
	output logic                  m_tlast    // last_piece
);

	localparam int unsigned POS_W   = OFFSET_BITS;
	localparam int unsigned FILL_W  = $clog2(MAX_DELIMITER_BYTES + 1);
	localparam int unsigned SEL_W   = (MAX_DELIMITER_BYTES > 1) ?
	                                  $clog2(MAX_DELIMITER_BYTES) : 1;
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned QPTR_W  = 2;
	localparam int unsigned QCNT_W  = 3;

	// Configuration registers
	logic [DLEN_W-1:0]   dlm_len_q;
	logic [DBYTES_W-1:0] dlm_bytes_q;
	logic [LIMIT_W-1:0]  limit_q;

	// String state
	logic [BYTE_W-1:0]   win_q [MAX_DELIMITER_BYTES];
	logic [FILL_W-1:0]   fill_q;
	logic [POS_W-1:0]    pos_q;
	logic [POS_W-1:0]    start_q;
	logic [FIELD_W-1:0]  pieces_q;
	logic                stopped_q;
	logic                ovf_q;

	// Output queue
	result_t             queue_q [Q_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	logic                in_acc;
	logic                out_acc;
	logic                byte_in;
	logic [DLEN_W-1:0]   len_eff;
	logic [BYTE_W-1:0]   win_new [MAX_DELIMITER_BYTES];
	logic [FILL_W-1:0]   fill_new;
	logic [MAX_DELIMITER_BYTES-1:0] len_hit;
	logic                pos_full;
	logic [POS_W-1:0]    pos_new;
	logic                ovf_new;
	logic                stop_pre;
	logic                stop_next;
	logic                match;
	logic [FIELD_W-1:0]  pieces_new;
	logic [POS_W:0]      cut_end;
	logic [POS_W-1:0]    plen;
	logic [POS_W-1:0]    start_new;
	logic [POS_W-1:0]    rlen;
	result_t             res_piece;
	result_t             res_rem;
	result_t             res_a;
	logic [1:0]          n_res;
	logic [QCNT_W-1:0]   n_push;

	// Handshakes
	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;
	assign s_tready = (count_q <= QCNT_W'(Q_DEPTH - 2));
	assign byte_in  = s_tuser;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dlm_len_q   <= DLEN_W'(1);
			dlm_bytes_q <= DBYTES_W'(44);
			limit_q     <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DELIM_LEN:   dlm_len_q   <= cfg_wdata[DLEN_W-1:0];
				REG_DELIM_BYTES: dlm_bytes_q <= cfg_wdata;
				REG_PIECE_LIMIT: limit_q     <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp delimiter length into the supported range
	always_comb begin
		if (dlm_len_q == '0)
			len_eff = DLEN_W'(1);
		else if (dlm_len_q > DLEN_W'(MAX_DELIMITER_BYTES))
			len_eff = DLEN_W'(MAX_DELIMITER_BYTES);
		else
			len_eff = dlm_len_q;
	end

	// Shift the new byte into the window, newest first
	always_comb begin
		win_new[0] = s_tdata;
		for (int i = 1; i < MAX_DELIMITER_BYTES; i++) begin
			win_new[i] = win_q[i-1];
		end
	end
	assign fill_new = (fill_q < FILL_W'(MAX_DELIMITER_BYTES)) ? fill_q + 1'b1 : fill_q;

	// Compare the window against the delimiter for every possible length
	for (genvar gl = 1; gl <= MAX_DELIMITER_BYTES; gl++) begin : g_len
		logic [gl-1:0] eq;
		for (genvar gk = 0; gk < gl; gk++) begin : g_byte
			assign eq[gk] = (win_new[gl-1-gk] == dlm_bytes_q[BYTE_W*gk +: BYTE_W]);
		end
		assign len_hit[gl-1] = (fill_new >= FILL_W'(gl)) && (&eq);
	end

	// Advance the byte position, saturating at the top of the offset range
	assign pos_full = &pos_q;
	assign pos_new  = (byte_in && !pos_full) ? pos_q + 1'b1 : pos_q;
	assign ovf_new  = ovf_q || (byte_in && pos_full);

	// Limit check before and after a cut
	always_comb begin
		logic cond_old;
		logic cond_new;
		cond_old   = (limit_q != '0) &&
		             (({1'b0, pieces_q} + 17'd1) >= {1'b0, limit_q});
		stop_pre   = stopped_q || (byte_in && cond_old);
		match      = byte_in && !stop_pre && len_hit[SEL_W'(len_eff - 1'b1)];
		pieces_new = (match && (pieces_q != '1)) ? pieces_q + 1'b1 : pieces_q;
		cond_new   = (limit_q != '0) &&
		             (({1'b0, pieces_new} + 17'd1) >= {1'b0, limit_q});
		stop_next  = stop_pre || (match && cond_new);
	end

	// Piece and remainder lengths
	assign cut_end   = {1'b0, start_q} + (POS_W+1)'(len_eff);
	assign plen      = ({1'b0, pos_new} >= cut_end) ?
	                   POS_W'({1'b0, pos_new} - cut_end) : '0;
	assign start_new = match ? pos_new : start_q;
	assign rlen      = pos_new - start_new;

	// Build result records
	always_comb begin
		res_piece.piece_start  = FIELD_W'(start_q);
		res_piece.piece_length = FIELD_W'(plen);
		res_piece.piece_index  = pieces_q;
		res_piece.last_piece   = 1'b0;
		res_piece.too_long     = ovf_new;

		res_rem.piece_start    = FIELD_W'(start_new);
		res_rem.piece_length   = FIELD_W'(rlen);
		res_rem.piece_index    = pieces_new;
		res_rem.last_piece     = 1'b1;
		res_rem.too_long       = ovf_new;

		res_a  = match ? res_piece : res_rem;
		n_res  = {1'b0, match} + {1'b0, s_tlast};
		n_push = in_acc ? QCNT_W'(n_res) : '0;
	end

	// Update string state; the end of a string clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			pos_q     <= '0;
			start_q   <= '0;
			pieces_q  <= '0;
			stopped_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (in_acc) begin
			if (s_tlast) begin
				fill_q    <= '0;
				pos_q     <= '0;
				start_q   <= '0;
				pieces_q  <= '0;
				stopped_q <= 1'b0;
				ovf_q     <= 1'b0;
			end else if (byte_in) begin
				fill_q    <= match ? '0 : fill_new;
				pos_q     <= pos_new;
				start_q   <= start_new;
				pieces_q  <= pieces_new;
				stopped_q <= stop_next;
				ovf_q     <= ovf_new;
			end
		end
	end

	// Hold the window bytes; only bytes below the fill count are compared
	always_ff @(posedge clk) begin
		if (in_acc && byte_in && !s_tlast) begin
			for (int i = 0; i < MAX_DELIMITER_BYTES; i++) begin
				win_q[i] <= win_new[i];
			end
		end
	end

	// Push up to two results into the output queue
	always_ff @(posedge clk) begin
		if (n_push != '0) begin
			queue_q[wr_ptr_q] <= res_a;
		end
		if (n_push == QCNT_W'(2)) begin
			queue_q[wr_ptr_q + 1'b1] <= res_rem;
		end
	end

	// Track queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + n_push - QCNT_W'(out_acc);
		end
	end

	// Drive the output channel from the queue head
	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {queue_q[rd_ptr_q].piece_index,
	                   queue_q[rd_ptr_q].piece_length,
	                   queue_q[rd_ptr_q].piece_start};
	assign m_tuser  = queue_q[rd_ptr_q].too_long;
	assign m_tlast  = queue_q[rd_ptr_q].last_piece;

endmodule
